// ----- rtl/core/collider_overlap_mtv_core_defines.svh -----
// Assertion macros shared by the collider overlap core.
`ifndef COLLIDER_OVERLAP_MTV_CORE_DEFINES_SVH
`define COLLIDER_OVERLAP_MTV_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked while out of reset.
`define COM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define COM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define COM_ASSERT(lbl, prop, msg)
`define COM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/core/com_pkg.sv -----
// Package with types, constants and helpers of the collider overlap core.
`default_nettype none
package com_pkg;

	localparam int CW = 32;
	localparam int SW = 31;
	localparam int FRAC_BITS = 16;
	localparam int SQRT_STEPS = 32;
	localparam int QW = FRAC_BITS + 1;
	localparam int REMW = CW + 2;

	typedef struct packed {
		logic                 mode;
		logic                 kind;
		logic signed [CW-1:0] center_x;
		logic signed [CW-1:0] center_y;
		logic signed [CW-1:0] center_z;
		logic        [SW-1:0] size_x;
		logic        [SW-1:0] size_y;
		logic        [SW-1:0] size_z;
	} item_t;

	typedef struct packed {
		logic                 hit;
		logic signed [CW-1:0] push_x;
		logic signed [CW-1:0] push_y;
		logic signed [CW-1:0] push_z;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EDGE,
		S_PREP,
		S_SQ,
		S_SQRT,
		S_EVAL,
		S_DIV,
		S_MUL,
		S_FINISH
	} state_t;

	localparam logic MODE_STORE = 1'b0;
	localparam logic MODE_TEST = 1'b1;
	localparam logic KIND_BOX = 1'b0;
	localparam logic KIND_SPHERE = 1'b1;

	// Saturate a wide signed value to the signed coordinate range.
	function automatic logic signed [CW-1:0] sat_c(input logic signed [CW+1:0] v);
		logic signed [CW+1:0] mx;
		logic signed [CW+1:0] mn;
		mx = $signed({{3{1'b0}}, {(CW-1){1'b1}}});
		mn = $signed({{3{1'b1}}, {(CW-1){1'b0}}});
		if (v > mx) begin
			sat_c = mx[CW-1:0];
		end else if (v < mn) begin
			sat_c = mn[CW-1:0];
		end else begin
			sat_c = v[CW-1:0];
		end
	endfunction

	// Sign-extend a coordinate to the wide working width.
	function automatic logic signed [CW+1:0] wide_c(input logic signed [CW-1:0] v);
		wide_c = {{2{v[CW-1]}}, v};
	endfunction

	// Half extent of a size, zero-extended to the wide working width.
	function automatic logic signed [CW+1:0] half_s(input logic [SW-1:0] s);
		half_s = $signed({4'b0000, s[SW-1:1]});
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/com_in_if.sv -----
// Valid/ready channel interface carrying one collider item.
`default_nettype none
interface com_in_if;
	logic            valid;
	logic            ready;
	com_pkg::item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/com_out_if.sv -----
// Valid/ready channel interface carrying one overlap result.
`default_nettype none
interface com_out_if;
	logic             valid;
	logic             ready;
	com_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/collider_overlap_mtv_core.sv -----
// Narrow-phase overlap test between a stored collider and an incoming one.
//
// Channel item carries colliders. A beat with mode 0 stores the collider as A
// and gives no result. A beat with mode 1 tests the collider against A and
// gives one beat on channel result: a hit flag and the push that moves A out.
// The core takes one item at a time; item.ready is high only while idle.
// A store leaves the core idle. A box-box test passes through the edge, prep
// and finish states, and its result is registered as it leaves finish.
// A test that involves a sphere runs a sequencer around one
// shared 32x32 multiplier, a bit-pair square root of 32 steps and a restoring
// divider of 17 steps per axis; a miss or a zero distance skips the divider.
// The result sits in an output register, so a stalled receiver holds only
// that beat; the next test finishes and waits until the register frees up.
// Reset makes A a zero-size box at the origin and drops any pending result.
`default_nettype none
`include "collider_overlap_mtv_core_defines.svh"
module collider_overlap_mtv_core (
	input  wire       clk,
	input  wire       arst_n,
	com_in_if.sink    item,
	com_out_if.source result
);
	import com_pkg::*;

	state_t state_q, state_d;

	// Stored collider A and registered collider B.
	logic                 akind_q;
	logic signed [CW-1:0] ac_q [3];
	logic        [SW-1:0] as_q [3];
	logic                 bkind_q;
	logic signed [CW-1:0] bc_q [3];
	logic        [SW-1:0] bs_q [3];

	// Box edges.
	logic signed [CW-1:0] alo_q [3];
	logic signed [CW-1:0] ahi_q [3];
	logic signed [CW-1:0] blo_q [3];
	logic signed [CW-1:0] bhi_q [3];

	// Sphere path working registers.
	logic        [CW-1:0] dmag_q [3];
	logic                 dneg_q [3];
	logic        [SW-1:0] rad_q;
	logic        [SW-1:0] pen_q;
	logic                 neg_q;
	logic        [2*CW-1:0] prod_q;
	logic        [2*CW-1:0] n_q;
	logic        [2*CW-1:0] res_q;
	logic        [2*CW-1:0] one_q;
	logic        [REMW-1:0] rem_q;
	logic        [QW-1:0]   q_q;
	logic        [5:0]      cnt_q;
	logic        [1:0]      ax_q;

	// Result being built and the output register.
	logic                 hit_q;
	logic signed [CW-1:0] push_q [3];
	logic                 ovalid_q;
	result_t              ores_q;

	logic accept;
	logic out_free;
	assign accept = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);
	assign out_free = !ovalid_q || result.ready;
	assign result.valid = ovalid_q;
	assign result.data = ores_q;

	// Shared multiplier.
	logic [CW-1:0]   mul_a;
	logic [2*CW-1:0] mul_p;
	always_comb begin
		if (state_q == S_MUL) begin
			mul_a = {{(CW-QW){1'b0}}, q_q};
		end else begin
			mul_a = dmag_q[ax_q];
		end
	end
	assign mul_p = (state_q == S_MUL) ? (mul_a * {{(CW-SW){1'b0}}, pen_q})
	                                  : (mul_a * mul_a);

	// Square root step.
	logic [2*CW-1:0] sq_t;
	logic            sq_ge;
	assign sq_t = res_q + one_q;
	assign sq_ge = (n_q >= sq_t);

	// Divider step.
	logic [CW-1:0]   dlen;
	logic [REMW-1:0] div_sh;
	logic            div_ge;
	assign dlen = res_q[CW-1:0];
	assign div_sh = (cnt_q == 6'd0) ? rem_q : {rem_q[REMW-2:0], 1'b0};
	assign div_ge = (div_sh >= {2'b00, dlen});

	// Penetration of a sphere case.
	logic signed [CW+1:0] pen_w;
	assign pen_w = $signed({3'b000, rad_q}) - $signed({2'b00, dlen});

	// Scaled push of the current axis.
	logic [SW-1:0] p_ax;
	logic          p_neg;
	assign p_ax = prod_q[FRAC_BITS+SW-1:FRAC_BITS];
	assign p_neg = dneg_q[ax_q] ^ neg_q;

	// Box-box overlaps and sphere-case differences.
	logic signed [CW-1:0] ov [3];
	logic signed [CW-1:0] dd [3];
	logic signed [CW-1:0] mn_hi, mx_lo, sc, cl;
	logic                 bb_hit;
	logic [1:0]           bb_ax;
	logic signed [CW:0]   asum, bsum;
	always_comb begin
		bb_hit = 1'b1;
		sc = '0;
		cl = '0;
		for (int i = 0; i < 3; i++) begin
			mn_hi = (ahi_q[i] < bhi_q[i]) ? ahi_q[i] : bhi_q[i];
			mx_lo = (alo_q[i] > blo_q[i]) ? alo_q[i] : blo_q[i];
			ov[i] = sat_c(wide_c(mn_hi) - wide_c(mx_lo));
			if (ov[i] <= 0) begin
				bb_hit = 1'b0;
			end
			if (akind_q && bkind_q) begin
				dd[i] = sat_c(wide_c(ac_q[i]) - wide_c(bc_q[i]));
			end else begin
				sc = akind_q ? ac_q[i] : bc_q[i];
				if (akind_q) begin
					cl = (sc < blo_q[i]) ? blo_q[i] : ((sc > bhi_q[i]) ? bhi_q[i] : sc);
				end else begin
					cl = (sc < alo_q[i]) ? alo_q[i] : ((sc > ahi_q[i]) ? ahi_q[i] : sc);
				end
				dd[i] = sat_c(wide_c(sc) - wide_c(cl));
			end
		end
		if (ov[0] <= ov[1] && ov[0] <= ov[2]) begin
			bb_ax = 2'd0;
		end else if (ov[1] <= ov[2]) begin
			bb_ax = 2'd1;
		end else begin
			bb_ax = 2'd2;
		end
		asum = {alo_q[bb_ax][CW-1], alo_q[bb_ax]} + {ahi_q[bb_ax][CW-1], ahi_q[bb_ax]};
		bsum = {blo_q[bb_ax][CW-1], blo_q[bb_ax]} + {bhi_q[bb_ax][CW-1], bhi_q[bb_ax]};
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && item.data.mode != MODE_STORE) begin
					state_d = S_EDGE;
				end
			end
			S_EDGE: state_d = S_PREP;
			S_PREP: begin
				if (akind_q == KIND_BOX && bkind_q == KIND_BOX) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_SQ;
				end
			end
			S_SQ: begin
				if (cnt_q == 6'd3) begin
					state_d = S_SQRT;
				end
			end
			S_SQRT: begin
				if (cnt_q == 6'(SQRT_STEPS - 1)) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (pen_w <= 0 || dlen == '0) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (cnt_q == 6'(FRAC_BITS)) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				if (cnt_q == 6'd1) begin
					state_d = (ax_q == 2'd2) ? S_FINISH : S_DIV;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Stored collider A.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			akind_q <= KIND_BOX;
			for (int i = 0; i < 3; i++) begin
				ac_q[i] <= '0;
				as_q[i] <= '0;
			end
		end else if (accept && item.data.mode == MODE_STORE) begin
			akind_q <= item.data.kind;
			ac_q[0] <= item.data.center_x;
			ac_q[1] <= item.data.center_y;
			ac_q[2] <= item.data.center_z;
			as_q[0] <= item.data.size_x;
			as_q[1] <= item.data.size_y;
			as_q[2] <= item.data.size_z;
		end
	end

	// Datapath registers under the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					bkind_q <= item.data.kind;
					bc_q[0] <= item.data.center_x;
					bc_q[1] <= item.data.center_y;
					bc_q[2] <= item.data.center_z;
					bs_q[0] <= item.data.size_x;
					bs_q[1] <= item.data.size_y;
					bs_q[2] <= item.data.size_z;
				end
			end
			S_EDGE: begin
				for (int i = 0; i < 3; i++) begin
					alo_q[i] <= sat_c(wide_c(ac_q[i]) - half_s(as_q[i]));
					ahi_q[i] <= sat_c(wide_c(ac_q[i]) + half_s(as_q[i]));
					blo_q[i] <= sat_c(wide_c(bc_q[i]) - half_s(bs_q[i]));
					bhi_q[i] <= sat_c(wide_c(bc_q[i]) + half_s(bs_q[i]));
				end
			end
			S_PREP: begin
				hit_q <= (akind_q == KIND_BOX && bkind_q == KIND_BOX) && bb_hit;
				for (int i = 0; i < 3; i++) begin
					dneg_q[i] <= dd[i][CW-1];
					dmag_q[i] <= dd[i][CW-1] ? CW'(-dd[i]) : CW'(dd[i]);
					if (akind_q == KIND_BOX && bkind_q == KIND_BOX && bb_hit &&
					    2'(i) == bb_ax) begin
						push_q[i] <= (asum < bsum) ? -ov[i] : ov[i];
					end else begin
						push_q[i] <= '0;
					end
				end
				if (akind_q == KIND_SPHERE && bkind_q == KIND_SPHERE) begin
					rad_q <= SW'(sat_c($signed({3'b000, as_q[0]}) + $signed({3'b000, bs_q[0]})));
				end else if (akind_q == KIND_SPHERE) begin
					rad_q <= as_q[0];
				end else begin
					rad_q <= bs_q[0];
				end
				neg_q <= (akind_q == KIND_BOX);
				n_q <= '0;
				cnt_q <= '0;
				ax_q <= '0;
			end
			S_SQ: begin
				if (cnt_q != 6'd3) begin
					prod_q <= mul_p;
				end
				if (cnt_q != 6'd0) begin
					n_q <= n_q + prod_q;
				end
				if (ax_q != 2'd2) begin
					ax_q <= ax_q + 2'd1;
				end
				res_q <= '0;
				one_q <= {2'b01, {(2*CW-2){1'b0}}};
				cnt_q <= (cnt_q == 6'd3) ? 6'd0 : cnt_q + 6'd1;
			end
			S_SQRT: begin
				if (sq_ge) begin
					n_q <= n_q - sq_t;
					res_q <= (res_q >> 1) + one_q;
				end else begin
					res_q <= res_q >> 1;
				end
				one_q <= one_q >> 2;
				cnt_q <= cnt_q + 6'd1;
			end
			S_EVAL: begin
				hit_q <= (pen_w > 0);
				pen_q <= pen_w[SW-1:0];
				if (pen_w > 0 && dlen == '0) begin
					push_q[1] <= neg_q ? -$signed({1'b0, pen_w[SW-1:0]})
					                   : $signed({1'b0, pen_w[SW-1:0]});
				end
				ax_q <= '0;
				cnt_q <= '0;
				rem_q <= {2'b00, dmag_q[0]};
				q_q <= '0;
			end
			S_DIV: begin
				rem_q <= div_ge ? (div_sh - {2'b00, dlen}) : div_sh;
				q_q <= {q_q[QW-2:0], div_ge};
				cnt_q <= (cnt_q == 6'(FRAC_BITS)) ? 6'd0 : cnt_q + 6'd1;
			end
			S_MUL: begin
				if (cnt_q == 6'd0) begin
					prod_q <= mul_p;
					cnt_q <= 6'd1;
				end else begin
					push_q[ax_q] <= p_neg ? -$signed({1'b0, p_ax}) : $signed({1'b0, p_ax});
					cnt_q <= '0;
					q_q <= '0;
					if (ax_q != 2'd2) begin
						ax_q <= ax_q + 2'd1;
						rem_q <= {2'b00, dmag_q[ax_q + 2'd1]};
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			ovalid_q <= 1'b1;
		end else if (result.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			ores_q.hit <= hit_q;
			ores_q.push_x <= hit_q ? push_q[0] : '0;
			ores_q.push_y <= hit_q ? push_q[1] : '0;
			ores_q.push_z <= hit_q ? push_q[2] : '0;
		end
	end

	`COM_ASSERT(a_test_starts, (accept && item.data.mode != MODE_STORE) |=> (state_q == S_EDGE), "test beat did not start the sequencer")
	`COM_ASSERT(a_store_idle, (accept && item.data.mode == MODE_STORE) |=> (state_q == S_IDLE), "store beat left idle")
	`COM_ASSERT(a_miss_zero, (ovalid_q && !ores_q.hit) |-> (ores_q.push_x == 0 && ores_q.push_y == 0 && ores_q.push_z == 0), "miss with nonzero push")
	`COM_ASSERT(a_div_count, (state_q == S_DIV) |-> (cnt_q <= 6'(FRAC_BITS)), "divider ran past its steps")
	`COM_ASSERT_ALWAYS(a_busy_not_ready, (state_q != S_IDLE) |-> !item.ready, "ready while busy")

endmodule
`default_nettype wire

// ----- tb/collider_overlap_mtv_core_test.sv -----
// Self-checking testbench for the collider overlap core, with its own push-vector predictor.
`timescale 1ns / 1ps
module collider_overlap_mtv_core_test;
	import com_pkg::*;

	localparam longint CMAX = 64'sd2147483647;
	localparam longint CMIN = -64'sd2147483648;
	localparam int RANDOM_ITEMS = 400;

	logic clk;
	logic arst_n;
	com_in_if item_ch ();
	com_out_if result_ch ();

	collider_overlap_mtv_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	// Collider A as the predictor holds it.
	logic   a_kind;
	longint a_center [3];
	longint a_size [3];

	item_t   pending_items [$];
	result_t expected_pushes [$];
	int      errors;
	int      tests_seen;
	int      hits_seen;
	int      stores_seen;
	bit      beat_taken;
	int      gap_left;
	int      burst_left;
	int      stall_mode;
	int      stall_cycle;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint clamp_c(input longint v);
		clamp_c = v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
	endfunction

	function automatic longint unsigned magnitude(input longint v);
		magnitude = v < 0 ? -v : v;
	endfunction

	// Floor of the Euclidean length, bit-pair square root on 128 bits.
	function automatic longint unsigned length_floor(input longint d [3]);
		logic [127:0] n;
		logic [127:0] res;
		logic [127:0] one;
		logic [127:0] m;
		n = 0;
		for (int i = 0; i < 3; i++) begin
			m = magnitude(d[i]);
			n = n + m * m;
		end
		res = 0;
		one = 128'd1 << 126;
		while (one != 0 && one > n) one = one >> 2;
		while (one != 0) begin
			if (n >= res + one) begin
				n = n - (res + one);
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		length_floor = res[63:0];
	endfunction

	// Scale the unit direction of d by the penetration depth; +y when d is zero.
	function automatic void scale_push(input longint d [3], input longint unsigned dlen,
		input longint pen, output longint push [3]);
		longint unsigned q;
		longint unsigned p;
		if (dlen == 0) begin
			push[0] = 0;
			push[1] = pen;
			push[2] = 0;
			return;
		end
		for (int i = 0; i < 3; i++) begin
			q = (magnitude(d[i]) << FRAC_BITS) / dlen;
			p = (q * longint'(pen)) >> FRAC_BITS;
			push[i] = d[i] < 0 ? -longint'(p) : longint'(p);
		end
	endfunction

	// Sphere against box: clamp the centre into the box and measure the gap.
	function automatic bit sphere_vs_box(input longint c [3], input longint r,
		input longint lo [3], input longint hi [3], output longint push [3]);
		longint d [3];
		longint cl;
		longint unsigned dlen;
		for (int i = 0; i < 3; i++) begin
			cl = c[i] < lo[i] ? lo[i] : (c[i] > hi[i] ? hi[i] : c[i]);
			d[i] = clamp_c(c[i] - cl);
		end
		dlen = length_floor(d);
		push = '{0, 0, 0};
		if (dlen >= r) return 1'b0;
		scale_push(d, dlen, r - longint'(dlen), push);
		return 1'b1;
	endfunction

	// Test collider B against the held collider A and give the separating push.
	function automatic result_t overlap_push(input item_t b);
		longint c [3];
		longint s [3];
		longint alo [3];
		longint ahi [3];
		longint blo [3];
		longint bhi [3];
		longint push [3];
		longint d [3];
		longint o [3];
		longint pen;
		longint unsigned dlen;
		bit hit;
		int ax;
		result_t r;
		c = '{longint'(b.center_x), longint'(b.center_y), longint'(b.center_z)};
		s = '{longint'({1'b0, b.size_x}), longint'({1'b0, b.size_y}),
			longint'({1'b0, b.size_z})};
		push = '{0, 0, 0};
		hit = 1'b0;
		for (int i = 0; i < 3; i++) begin
			alo[i] = clamp_c(a_center[i] - (a_size[i] >>> 1));
			ahi[i] = clamp_c(a_center[i] + (a_size[i] >>> 1));
			blo[i] = clamp_c(c[i] - (s[i] >>> 1));
			bhi[i] = clamp_c(c[i] + (s[i] >>> 1));
		end
		if (a_kind == KIND_SPHERE && b.kind == KIND_SPHERE) begin
			for (int i = 0; i < 3; i++) d[i] = clamp_c(a_center[i] - c[i]);
			dlen = length_floor(d);
			pen = clamp_c(clamp_c(a_size[0] + s[0]) - longint'(dlen));
			if (pen > 0) begin
				hit = 1'b1;
				scale_push(d, dlen, pen, push);
			end
		end else if (a_kind == KIND_SPHERE) begin
			hit = sphere_vs_box(a_center, a_size[0], blo, bhi, push);
		end else if (b.kind == KIND_SPHERE) begin
			// Box against sphere is the sphere-box push turned around.
			hit = sphere_vs_box(c, s[0], alo, ahi, push);
			if (hit) for (int i = 0; i < 3; i++) push[i] = clamp_c(-push[i]);
		end else begin
			for (int i = 0; i < 3; i++)
				o[i] = clamp_c((ahi[i] < bhi[i] ? ahi[i] : bhi[i])
					- (alo[i] > blo[i] ? alo[i] : blo[i]));
			if (o[0] > 0 && o[1] > 0 && o[2] > 0) begin
				hit = 1'b1;
				if (o[0] <= o[1] && o[0] <= o[2]) ax = 0;
				else if (o[1] <= o[2]) ax = 1;
				else ax = 2;
				push[ax] = (alo[ax] + ahi[ax] < blo[ax] + bhi[ax]) ? -o[ax] : o[ax];
			end
		end
		if (!hit) push = '{0, 0, 0};
		r.hit = hit;
		r.push_x = clamp_c(push[0]);
		r.push_y = clamp_c(push[1]);
		r.push_z = clamp_c(push[2]);
		return r;
	endfunction

	function automatic item_t collider(input logic mode, input logic kind,
		input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
		input logic [30:0] sx, input logic [30:0] sy, input logic [30:0] sz);
		item_t it;
		it.mode = mode;
		it.kind = kind;
		it.center_x = cx;
		it.center_y = cy;
		it.center_z = cz;
		it.size_x = sx;
		it.size_y = sy;
		it.size_z = sz;
		return it;
	endfunction

	// Random size: mostly moderate, sometimes any 31-bit value.
	function automatic logic [30:0] rand_size();
		if ($urandom_range(0, 9) == 0) return 31'($urandom);
		return 31'($urandom_range(0, 32'h0008_0000));
	endfunction

	function automatic logic [31:0] near(input logic [31:0] base);
		return base + $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
	endfunction

	// Monitor: predict on each accepted item beat, check each result beat.
	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (item_ch.valid && item_ch.ready) begin
			beat_taken = 1'b1;
			if (item_ch.data.mode == MODE_STORE) begin
				a_kind = item_ch.data.kind;
				a_center = '{longint'(item_ch.data.center_x),
					longint'(item_ch.data.center_y), longint'(item_ch.data.center_z)};
				a_size = '{longint'({1'b0, item_ch.data.size_x}),
					longint'({1'b0, item_ch.data.size_y}),
					longint'({1'b0, item_ch.data.size_z})};
				stores_seen++;
			end else begin
				expected_pushes.push_back(overlap_push(item_ch.data));
			end
		end
		if (result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (expected_pushes.size() == 0) begin
				$display("%0t: result beat with nothing expected: hit %0b push %0d %0d %0d",
					$time, got.hit, got.push_x, got.push_y, got.push_z);
				errors++;
			end else begin
				want = expected_pushes.pop_front();
				tests_seen++;
				if (want.hit) hits_seen++;
				if (got.hit !== want.hit) begin
					$display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
					errors++;
				end
				if (got.push_x !== want.push_x) begin
					$display("%0t: push_x expected %0d actual %0d", $time,
						want.push_x, got.push_x);
					errors++;
				end
				if (got.push_y !== want.push_y) begin
					$display("%0t: push_y expected %0d actual %0d", $time,
						want.push_y, got.push_y);
					errors++;
				end
				if (got.push_z !== want.push_z) begin
					$display("%0t: push_z expected %0d actual %0d", $time,
						want.push_z, got.push_z);
					errors++;
				end
			end
		end
	end

	// Driver: sends beats in bursts of random length with random gaps, never in reset.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || beat_taken) begin
			beat_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				item_ch.valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				item_ch.data <= pending_items.pop_front();
				item_ch.valid <= 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 20);
				end else begin
					burst_left--;
				end
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: its stall pattern is picked at random from four patterns.
	always @(negedge clk) begin
		stall_cycle++;
		if (stall_cycle % 256 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: begin
				result_ch.ready <= 1'b1;
			end
			1: begin
				result_ch.ready <= (stall_cycle % 4) != 3;
			end
			2: begin
				result_ch.ready <= (stall_cycle % 64) >= 40;
			end
			default: begin
				result_ch.ready <= $urandom_range(0, 2) != 0;
			end
		endcase
	end

	// Run limit.
	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [31:0] bx;
		logic [31:0] by;
		logic [31:0] bz;
		logic kind_a;
		errors = 0;
		tests_seen = 0;
		hits_seen = 0;
		stores_seen = 0;
		beat_taken = 1'b0;
		gap_left = 0;
		burst_left = 0;
		stall_mode = 0;
		stall_cycle = 0;
		a_kind = KIND_BOX;
		a_center = '{0, 0, 0};
		a_size = '{0, 0, 0};
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
		arst_n = 1'b0;

		// Directed: test before any store, then each shape pairing and corner case.
		pending_items.push_back(collider(MODE_TEST, KIND_BOX, 0, 0, 0,
			31'h20000, 31'h20000, 31'h20000));
		pending_items.push_back(collider(MODE_TEST, KIND_SPHERE, 32'h8000, 0, 0,
			31'h10000, 0, 0));
		pending_items.push_back(collider(MODE_STORE, KIND_BOX, 0, 0, 0,
			31'h40000, 31'h40000, 31'h40000));
		pending_items.push_back(collider(MODE_TEST, KIND_BOX, 32'h10000, 0, 0,
			31'h40000, 31'h40000, 31'h40000));
		pending_items.push_back(collider(MODE_TEST, KIND_BOX, 0, 0, 0,
			31'h40000, 31'h40000, 31'h40000));
		pending_items.push_back(collider(MODE_TEST, KIND_BOX, 32'h40000, 0, 0,
			31'h40000, 31'h40000, 31'h40000));
		pending_items.push_back(collider(MODE_TEST, KIND_SPHERE, 32'h30000, 32'h10000, 0,
			31'h20000, 0, 0));
		pending_items.push_back(collider(MODE_TEST, KIND_SPHERE, 0, 0, 0, 31'h10000, 0, 0));
		pending_items.push_back(collider(MODE_STORE, KIND_SPHERE, 0, 0, 0,
			31'h20000, 31'h7fffffff, 0));
		pending_items.push_back(collider(MODE_TEST, KIND_SPHERE, 0, 0, 0, 31'h20000, 0, 0));
		pending_items.push_back(collider(MODE_TEST, KIND_SPHERE, 32'h18000, 32'hffff0000,
			32'h8000, 31'h20000, 0, 0));
		pending_items.push_back(collider(MODE_TEST, KIND_BOX, 32'h28000, 0, 0,
			31'h20000, 31'h20000, 31'h20000));
		pending_items.push_back(collider(MODE_TEST, KIND_BOX, 0, 0, 0,
			31'h20000, 31'h20000, 31'h20000));
		pending_items.push_back(collider(MODE_TEST, KIND_SPHERE, 32'h7fffffff, 32'h80000000, 0,
			31'h7fffffff, 0, 0));
		pending_items.push_back(collider(MODE_STORE, KIND_BOX, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
		pending_items.push_back(collider(MODE_TEST, KIND_BOX, 32'h80000000, 32'h7fffffff,
			32'h80000000, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
		pending_items.push_back(collider(MODE_TEST, KIND_SPHERE, 32'h80000000, 32'h7fffffff, 0,
			31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
		pending_items.push_back(collider(MODE_STORE, KIND_SPHERE, 32'h80000000, 32'h80000000,
			32'h80000000, 31'h7fffffff, 0, 0));
		pending_items.push_back(collider(MODE_TEST, KIND_SPHERE, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 31'h7fffffff, 0, 0));
		pending_items.push_back(collider(MODE_TEST, KIND_BOX, 32'h80000000, 32'h80000000,
			32'h80000000, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
		pending_items.push_back(collider(MODE_STORE, KIND_BOX, 0, 0, 0,
			31'h40000, 31'h30000, 31'h50000));
		pending_items.push_back(collider(MODE_TEST, KIND_BOX, 32'h8000, 32'h8000, 0,
			31'h40000, 31'h30000, 31'h50000));

		// Random: mostly a store followed by nearby tests, some fully random beats.
		for (int n = 0; n < RANDOM_ITEMS; ) begin
			if ($urandom_range(0, 7) == 0) begin
				pending_items.push_back(collider(1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
					31'($urandom), 31'($urandom), 31'($urandom)));
				n++;
			end else begin
				bx = $urandom;
				by = $urandom;
				bz = $urandom;
				kind_a = 1'($urandom_range(0, 1));
				pending_items.push_back(collider(MODE_STORE, kind_a, bx, by, bz,
					rand_size(), rand_size(), rand_size()));
				n++;
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 5) == 0)
						pending_items.push_back(collider(MODE_TEST, 1'($urandom_range(0, 1)),
							bx, by, bz, rand_size(), rand_size(), rand_size()));
					else
						pending_items.push_back(collider(MODE_TEST, 1'($urandom_range(0, 1)),
							near(bx), near(by), near(bz),
							rand_size(), rand_size(), rand_size()));
					n++;
				end
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_items.size() == 0);
		@(posedge clk);
		while (item_ch.valid) @(posedge clk);
		while (expected_pushes.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("Covered %0d stores and %0d tests, %0d of them hits.",
			stores_seen, tests_seen, hits_seen);
		$display("Mismatches found: %0d.", errors);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
